// ===== rtl/pmea_pkg.sv =====
// Package for the packet majority error analyser.
// Holds the shared widths, result codes, controller states and the command/status types.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package pmea_pkg;

  localparam int MAX_BYTES_DEF = 127;
  localparam int CNT_W         = 7;
  localparam int DATA_W        = 8;
  localparam int TIME_W        = 32;
  localparam int MASK_W        = 64;
  localparam int NVALUES       = 256;
  localparam int BYTE_SEL_W    = 5;

  localparam logic [DATA_W-1:0] LO_NIBBLE = 8'h0f;
  localparam logic [DATA_W-1:0] HI_NIBBLE = 8'hf0;

  localparam logic [1:0] KIND_UNDECIDED = 2'd0;
  localparam logic [1:0] KIND_SUMMARY   = 2'd1;
  localparam logic [1:0] KIND_MASK      = 2'd2;

  typedef enum logic [2:0] {
    S_IDLE,
    S_UPDATE,
    S_DECIDE,
    S_READ,
    S_ACCUM,
    S_EMIT
  } state_t;

  typedef struct packed {
    logic capture;
    logic update;
    logic decide;
    logic read;
    logic accum;
    logic emit_mask;
  } cmd_t;

  typedef struct packed {
    logic eop;
    logic undecided;
    logic words_zero;
    logic word_end;
    logic scan_done;
  } stat_t;

endpackage

`default_nettype wire

// ===== rtl/pmea_ctrl.sv =====
// Controller state machine of the packet majority error analyser.
// Sequences the byte update, the decision and the stored-byte scan; uses pmea_pkg.
`timescale 1ns / 1ps
`default_nettype none

module pmea_ctrl (
  input  wire logic            clk,
  input  wire logic            rst_n,
  input  wire logic            start,
  input  wire pmea_pkg::stat_t stat,
  output pmea_pkg::cmd_t       cmd,
  output logic                 busy
);

  pmea_pkg::state_t state_r;
  pmea_pkg::state_t state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= pmea_pkg::S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      pmea_pkg::S_IDLE: begin
        if (start) begin
          state_nxt = pmea_pkg::S_UPDATE;
        end
      end
      pmea_pkg::S_UPDATE: begin
        state_nxt = stat.eop ? pmea_pkg::S_DECIDE : pmea_pkg::S_IDLE;
      end
      pmea_pkg::S_DECIDE: begin
        if (stat.undecided || stat.words_zero) begin
          state_nxt = pmea_pkg::S_IDLE;
        end else begin
          state_nxt = pmea_pkg::S_READ;
        end
      end
      pmea_pkg::S_READ: begin
        state_nxt = pmea_pkg::S_ACCUM;
      end
      pmea_pkg::S_ACCUM: begin
        state_nxt = stat.word_end ? pmea_pkg::S_EMIT : pmea_pkg::S_READ;
      end
      pmea_pkg::S_EMIT: begin
        state_nxt = stat.scan_done ? pmea_pkg::S_IDLE : pmea_pkg::S_READ;
      end
      default: begin
        state_nxt = pmea_pkg::S_IDLE;
      end
    endcase
  end

  always_comb begin
    cmd       = '0;
    busy      = 1'b1;
    case (state_r)
      pmea_pkg::S_IDLE: begin
        busy        = 1'b0;
        cmd.capture = start;
      end
      pmea_pkg::S_UPDATE: begin
        cmd.update = 1'b1;
      end
      pmea_pkg::S_DECIDE: begin
        cmd.decide = 1'b1;
      end
      pmea_pkg::S_READ: begin
        cmd.read = 1'b1;
      end
      pmea_pkg::S_ACCUM: begin
        cmd.accum = 1'b1;
      end
      pmea_pkg::S_EMIT: begin
        cmd.emit_mask = 1'b1;
      end
      default: begin
        busy = 1'b1;
      end
    endcase
  end

endmodule

`default_nettype wire

// ===== rtl/pmea_dp.sv =====
// Datapath of the packet majority error analyser.
// Holds the packet store, the byte histogram, the leader and sequence state and the
// result registers; driven by pmea_ctrl through pmea_pkg command and status types.
`timescale 1ns / 1ps
`default_nettype none

module pmea_dp #(
  parameter int MAX_BYTES = pmea_pkg::MAX_BYTES_DEF
) (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  input  wire pmea_pkg::cmd_t                cmd,
  input  wire logic [pmea_pkg::DATA_W-1:0]   in_data_byte,
  input  wire logic                          in_end_of_packet,
  input  wire logic [pmea_pkg::TIME_W-1:0]   in_timestamp_us,
  output pmea_pkg::stat_t                    stat,
  output logic                               out_valid,
  output logic [1:0]                         out_kind,
  output logic [7:0]                         out_nibble_count,
  output logic [7:0]                         out_lost_count,
  output logic [pmea_pkg::TIME_W-1:0]        out_relative_time_us,
  output logic [1:0]                         out_word_index,
  output logic [pmea_pkg::MASK_W-1:0]        out_error_mask,
  output logic                               out_last_result
);

  localparam int ADDR_W = (MAX_BYTES > 1) ? $clog2(MAX_BYTES) : 1;
  localparam int CW     = pmea_pkg::CNT_W;
  localparam int DW     = pmea_pkg::DATA_W;
  localparam int TW     = pmea_pkg::TIME_W;
  localparam int MW     = pmea_pkg::MASK_W;
  localparam int SW     = pmea_pkg::BYTE_SEL_W;

  logic [DW-1:0]                  store_mem [MAX_BYTES];
  logic [CW-1:0]                  hist_mem  [pmea_pkg::NVALUES];
  logic [pmea_pkg::NVALUES-1:0]   hist_vld_r;
  logic [CW-1:0]                  hist_rd_r;
  logic [DW-1:0]                  store_rd_r;

  logic [DW-1:0]  byte_r;
  logic           eop_r;
  logic [TW-1:0]  ts_r;

  logic [CW-1:0]  byte_count_r;
  logic [DW-1:0]  leader_r;
  logic [CW-1:0]  leader_cnt_r;
  logic [DW-1:0]  prev_maj_r;
  logic           prev_vld_r;
  logic [TW-1:0]  first_time_r;
  logic           time_vld_r;
  logic [CW-1:0]  scan_idx_r;
  logic [1:0]     word_r;
  logic [MW-1:0]  mask_r;

  logic           out_valid_r;
  logic [1:0]     out_kind_r;
  logic [7:0]     out_nib_r;
  logic [7:0]     out_lost_r;
  logic [TW-1:0]  out_rel_r;
  logic [1:0]     out_word_r;
  logic [MW-1:0]  out_mask_r;
  logic           out_last_r;

  logic [CW-1:0]  cur_cnt;
  logic [CW-1:0]  cnt_nxt;
  logic           room;
  logic           undecided;
  logic           words_zero;
  logic [TW-1:0]  rel_time;
  logic [DW-1:0]  lost;
  logic [DW-1:0]  diff;
  logic [CW-1:0]  scan_inc;
  logic           scan_done;
  logic           finish_dec;
  logic           clear_pkt;
  logic [5:0]     bit_lo;
  logic [5:0]     bit_hi;

  assign cur_cnt    = hist_vld_r[byte_r] ? hist_rd_r : '0;
  assign cnt_nxt    = cur_cnt + CW'(1);
  assign room       = byte_count_r < CW'(MAX_BYTES);
  assign undecided  = (leader_cnt_r <= (byte_count_r >> 1)) && (leader_cnt_r != byte_count_r);
  assign words_zero = byte_count_r == '0;
  assign rel_time   = ts_r - (time_vld_r ? first_time_r : ts_r);
  assign lost       = prev_vld_r ? (leader_r - prev_maj_r - DW'(1)) : '0;
  assign diff       = store_rd_r ^ leader_r;
  assign scan_inc   = scan_idx_r + CW'(1);
  assign scan_done  = scan_idx_r == byte_count_r;
  assign bit_lo     = {scan_idx_r[SW-1:0], 1'b0};
  assign bit_hi     = {scan_idx_r[SW-1:0], 1'b1};

  assign finish_dec = (cmd.decide && !undecided && words_zero) || (cmd.emit_mask && scan_done);
  assign clear_pkt  = (cmd.decide && (undecided || words_zero)) || (cmd.emit_mask && scan_done);

  assign stat.eop        = eop_r;
  assign stat.undecided  = undecided;
  assign stat.words_zero = words_zero;
  assign stat.word_end   = (scan_inc == byte_count_r) || (scan_idx_r[SW-1:0] == '1);
  assign stat.scan_done  = scan_done;

  // The histogram and packet store are plain memories with registered reads.
  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      hist_rd_r <= hist_mem[in_data_byte];
    end
    if (cmd.update && room) begin
      hist_mem[byte_r]                       <= cnt_nxt;
      store_mem[byte_count_r[ADDR_W-1:0]]    <= byte_r;
    end
    if (cmd.read) begin
      store_rd_r <= store_mem[scan_idx_r[ADDR_W-1:0]];
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      byte_r <= in_data_byte;
      eop_r  <= in_end_of_packet;
      ts_r   <= in_timestamp_us;
    end
    if (cmd.decide) begin
      scan_idx_r <= '0;
      word_r     <= '0;
      mask_r     <= '0;
    end
    if (cmd.accum) begin
      mask_r[bit_lo] <= |(diff & pmea_pkg::LO_NIBBLE);
      mask_r[bit_hi] <= |(diff & pmea_pkg::HI_NIBBLE);
      scan_idx_r     <= scan_inc;
    end
    if (cmd.emit_mask) begin
      mask_r <= '0;
      word_r <= word_r + 2'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      hist_vld_r   <= '0;
      byte_count_r <= '0;
      leader_r     <= '0;
      leader_cnt_r <= '0;
      prev_maj_r   <= '0;
      prev_vld_r   <= 1'b0;
      first_time_r <= '0;
      time_vld_r   <= 1'b0;
    end else begin
      if (cmd.update && room) begin
        hist_vld_r[byte_r] <= 1'b1;
        byte_count_r       <= byte_count_r + CW'(1);
        if (byte_r == leader_r) begin
          leader_cnt_r <= cnt_nxt;
        end else if ((byte_count_r == '0) || (cnt_nxt > leader_cnt_r)) begin
          leader_r     <= byte_r;
          leader_cnt_r <= cnt_nxt;
        end
      end
      if (cmd.decide) begin
        if (!time_vld_r) begin
          first_time_r <= ts_r;
          time_vld_r   <= 1'b1;
        end
        if (undecided && prev_vld_r) begin
          prev_maj_r <= prev_maj_r + DW'(1);
        end
      end
      if (finish_dec) begin
        prev_maj_r <= leader_r;
        prev_vld_r <= 1'b1;
      end
      if (clear_pkt) begin
        hist_vld_r   <= '0;
        byte_count_r <= '0;
        leader_r     <= '0;
        leader_cnt_r <= '0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= cmd.decide || cmd.emit_mask;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.decide) begin
      out_kind_r <= undecided ? pmea_pkg::KIND_UNDECIDED : pmea_pkg::KIND_SUMMARY;
      out_nib_r  <= {byte_count_r, 1'b0};
      out_lost_r <= undecided ? '0 : lost;
      out_rel_r  <= rel_time;
      out_word_r <= '0;
      out_mask_r <= '0;
      out_last_r <= undecided || words_zero;
    end else if (cmd.emit_mask) begin
      out_kind_r <= pmea_pkg::KIND_MASK;
      out_nib_r  <= '0;
      out_lost_r <= '0;
      out_rel_r  <= '0;
      out_word_r <= word_r;
      out_mask_r <= mask_r;
      out_last_r <= scan_done;
    end
  end

  assign out_valid            = out_valid_r;
  assign out_kind             = out_kind_r;
  assign out_nibble_count     = out_nib_r;
  assign out_lost_count       = out_lost_r;
  assign out_relative_time_us = out_rel_r;
  assign out_word_index       = out_word_r;
  assign out_error_mask       = out_mask_r;
  assign out_last_result      = out_last_r;

endmodule

`default_nettype wire

// ===== rtl/packet_majority_error_analyzer.sv =====
// Packet majority error analyser: each byte passes through the update state before busy falls.
// The last byte adds the decision state, then, for a decided packet, a read and an accumulate state per
// stored byte for the store scan (one read port on the packet store) and an emit state per 64-nibble mask word.
// Each result is registered and strobed on out_valid for one cycle; the receiver cannot stall.
// Synchronous active-low reset clears the histogram valid bits and all sequence state.
// Uses pmea_pkg, pmea_ctrl and pmea_dp.
`timescale 1ns / 1ps
`default_nettype none

module packet_majority_error_analyzer #(
  parameter int MAX_BYTES = pmea_pkg::MAX_BYTES_DEF
) (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  input  wire logic                          start,
  output logic                               busy,
  input  wire logic [pmea_pkg::DATA_W-1:0]   in_data_byte,
  input  wire logic                          in_end_of_packet,
  input  wire logic [pmea_pkg::TIME_W-1:0]   in_timestamp_us,
  output logic                               out_valid,
  output logic [1:0]                         out_kind,
  output logic [7:0]                         out_nibble_count,
  output logic [7:0]                         out_lost_count,
  output logic [pmea_pkg::TIME_W-1:0]        out_relative_time_us,
  output logic [1:0]                         out_word_index,
  output logic [pmea_pkg::MASK_W-1:0]        out_error_mask,
  output logic                               out_last_result
);

  pmea_pkg::cmd_t  cmd;
  pmea_pkg::stat_t stat;

  pmea_ctrl u_ctrl (
    .clk   (clk),
    .rst_n (rst_n),
    .start (start),
    .stat  (stat),
    .cmd   (cmd),
    .busy  (busy)
  );

  pmea_dp #(
    .MAX_BYTES (MAX_BYTES)
  ) u_dp (
    .clk                  (clk),
    .rst_n                (rst_n),
    .cmd                  (cmd),
    .in_data_byte         (in_data_byte),
    .in_end_of_packet     (in_end_of_packet),
    .in_timestamp_us      (in_timestamp_us),
    .stat                 (stat),
    .out_valid            (out_valid),
    .out_kind             (out_kind),
    .out_nibble_count     (out_nibble_count),
    .out_lost_count       (out_lost_count),
    .out_relative_time_us (out_relative_time_us),
    .out_word_index       (out_word_index),
    .out_error_mask       (out_error_mask),
    .out_last_result      (out_last_result)
  );

endmodule

`default_nettype wire

// ===== tb/tb_packet_majority_error_analyzer.sv =====
// Self-checking testbench for the packet majority error analyser.
// Holds a scoreboard class that predicts the per-packet results, and the tasks that drive
// the beats. Depends on pmea_pkg and packet_majority_error_analyzer.
`timescale 1ns / 1ps

module tb_packet_majority_error_analyzer;

  localparam int DATA_W      = pmea_pkg::DATA_W;
  localparam int CNT_W       = pmea_pkg::CNT_W;
  localparam int TIME_W      = pmea_pkg::TIME_W;
  localparam int MASK_W      = pmea_pkg::MASK_W;
  localparam int NVALUES     = pmea_pkg::NVALUES;
  localparam int STORE_DEPTH = pmea_pkg::MAX_BYTES_DEF;
  localparam int STALL_LIMIT = 2000;
  localparam int TAIL_CYCLES = 16;

  typedef struct packed {
    logic [1:0]        kind;
    logic [7:0]        nibble_count;
    logic [7:0]        lost_count;
    logic [TIME_W-1:0] relative_time_us;
    logic [1:0]        word_index;
    logic [MASK_W-1:0] error_mask;
    logic              last_result;
  } analysis_result_t;

  class packet_analysis_scoreboard;
    logic [DATA_W-1:0] byte_store [STORE_DEPTH];
    logic [CNT_W-1:0]  value_hist [NVALUES];
    logic [CNT_W-1:0]  stored_bytes;
    logic [DATA_W-1:0] leader;
    logic [DATA_W-1:0] last_majority;
    bit                last_majority_ok;
    logic [TIME_W-1:0] origin_us;
    bit                origin_ok;
    analysis_result_t  expected_results [$];
    int                mismatches;

    function new();
      mismatches = 0;
      last_majority = '0;
      last_majority_ok = 0;
      origin_us = '0;
      origin_ok = 0;
      clear_packet();
    endfunction

    function void clear_packet();
      foreach (value_hist[v]) value_hist[v] = '0;
      stored_bytes = '0;
      leader = '0;
    endfunction

    function int pending_count();
      return expected_results.size();
    endfunction

    task report_mismatch(input string msg);
      $display("mismatch at %0t: %s", $realtime, msg);
      mismatches++;
    endtask

    function void note_input_beat(input logic [DATA_W-1:0] data, input logic eop,
                                  input logic [TIME_W-1:0] stamp);
      int                len;
      int                words;
      int                w;
      int                i;
      logic [CNT_W-1:0]  lead_n;
      logic [DATA_W-1:0] diff;
      logic [MASK_W-1:0] mask;
      analysis_result_t  r;
      if (stored_bytes < STORE_DEPTH) begin
        byte_store[stored_bytes] = data;
        value_hist[data] = value_hist[data] + 1'b1;
        if (stored_bytes == 0 || value_hist[data] > value_hist[leader]) begin
          leader = data;
        end
        stored_bytes = stored_bytes + 1'b1;
      end
      if (!eop) return;
      if (!origin_ok) begin
        origin_us = stamp;
        origin_ok = 1;
      end
      len = stored_bytes;
      lead_n = value_hist[leader];
      r = '0;
      r.nibble_count = 8'(len * 2);
      r.relative_time_us = stamp - origin_us;
      if (lead_n <= len / 2 && lead_n != len) begin
        r.kind = pmea_pkg::KIND_UNDECIDED;
        r.last_result = 1'b1;
        expected_results.push_back(r);
        if (last_majority_ok) last_majority = last_majority + 8'd1;
        clear_packet();
        return;
      end
      words = (len * 2 + 63) / 64;
      r.kind = pmea_pkg::KIND_SUMMARY;
      r.lost_count = last_majority_ok ? 8'(leader - last_majority - 8'd1) : 8'd0;
      r.last_result = (words == 0);
      expected_results.push_back(r);
      for (w = 0; w < words && w < 4; w++) begin
        mask = '0;
        for (i = w * 32; i < len && i < w * 32 + 32; i++) begin
          diff = byte_store[i] ^ leader;
          if (|(diff & pmea_pkg::LO_NIBBLE)) mask[(i - w * 32) * 2] = 1'b1;
          if (|(diff & pmea_pkg::HI_NIBBLE)) mask[(i - w * 32) * 2 + 1] = 1'b1;
        end
        r = '0;
        r.kind = pmea_pkg::KIND_MASK;
        r.word_index = 2'(w);
        r.error_mask = mask;
        r.last_result = (w + 1 == words);
        expected_results.push_back(r);
      end
      last_majority = leader;
      last_majority_ok = 1;
      clear_packet();
    endfunction

    task check_result_beat(input analysis_result_t got);
      analysis_result_t want;
      if (expected_results.size() == 0) begin
        report_mismatch($sformatf("unexpected result beat of kind %0d", got.kind));
        return;
      end
      want = expected_results.pop_front();
      if (got.kind !== want.kind)
        report_mismatch($sformatf("kind %0h, want %0h", got.kind, want.kind));
      if (got.nibble_count !== want.nibble_count)
        report_mismatch($sformatf("nibble_count %0h, want %0h",
                                  got.nibble_count, want.nibble_count));
      if (got.lost_count !== want.lost_count)
        report_mismatch($sformatf("lost_count %0h, want %0h",
                                  got.lost_count, want.lost_count));
      if (got.relative_time_us !== want.relative_time_us)
        report_mismatch($sformatf("relative_time_us %0h, want %0h",
                                  got.relative_time_us, want.relative_time_us));
      if (got.word_index !== want.word_index)
        report_mismatch($sformatf("word_index %0h, want %0h",
                                  got.word_index, want.word_index));
      if (got.error_mask !== want.error_mask)
        report_mismatch($sformatf("error_mask %0h, want %0h",
                                  got.error_mask, want.error_mask));
      if (got.last_result !== want.last_result)
        report_mismatch($sformatf("last_result %0h, want %0h",
                                  got.last_result, want.last_result));
    endtask
  endclass

  logic              clk;
  logic              rst_n;
  logic              start;
  logic              busy;
  logic [DATA_W-1:0] in_data_byte;
  logic              in_end_of_packet;
  logic [TIME_W-1:0] in_timestamp_us;
  logic              out_valid;
  logic [1:0]        out_kind;
  logic [7:0]        out_nibble_count;
  logic [7:0]        out_lost_count;
  logic [TIME_W-1:0] out_relative_time_us;
  logic [1:0]        out_word_index;
  logic [MASK_W-1:0] out_error_mask;
  logic              out_last_result;

  packet_analysis_scoreboard sb = new();
  logic [DATA_W-1:0] pkt_q [$];
  int                idle_pct = 0;

  packet_majority_error_analyzer u_dut (
    .clk                  (clk),
    .rst_n                (rst_n),
    .start                (start),
    .busy                 (busy),
    .in_data_byte         (in_data_byte),
    .in_end_of_packet     (in_end_of_packet),
    .in_timestamp_us      (in_timestamp_us),
    .out_valid            (out_valid),
    .out_kind             (out_kind),
    .out_nibble_count     (out_nibble_count),
    .out_lost_count       (out_lost_count),
    .out_relative_time_us (out_relative_time_us),
    .out_word_index       (out_word_index),
    .out_error_mask       (out_error_mask),
    .out_last_result      (out_last_result)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  always @(posedge clk) begin
    if (rst_n === 1'b1 && out_valid === 1'b1) begin
      sb.check_result_beat('{out_kind, out_nibble_count, out_lost_count,
                             out_relative_time_us, out_word_index, out_error_mask,
                             out_last_result});
    end
  end

  initial begin : watchdog
    int quiet;
    quiet = 0;
    while (quiet < STALL_LIMIT) begin
      @(posedge clk);
      if ((start === 1'b1 && busy === 1'b0) || out_valid === 1'b1) quiet = 0;
      else quiet++;
    end
    $display("TB_ERROR");
    $finish;
  end

  // Sends the bytes in pkt_q as one packet; the timestamp only matters on the last beat.
  task automatic send_packet(input logic [TIME_W-1:0] stamp);
    int i;
    for (i = 0; i < pkt_q.size(); i++) begin
      while ($urandom_range(99) < idle_pct) begin
        start = 1'b0;
        in_data_byte = DATA_W'($urandom);
        @(negedge clk);
      end
      start = 1'b1;
      in_data_byte = pkt_q[i];
      in_end_of_packet = (i == pkt_q.size() - 1);
      in_timestamp_us = in_end_of_packet ? stamp : TIME_W'($urandom);
      do @(posedge clk); while (busy !== 1'b0);
      sb.note_input_beat(in_data_byte, in_end_of_packet, in_timestamp_us);
      @(negedge clk);
    end
  endtask

  task automatic wait_drained();
    start = 1'b0;
    while (sb.pending_count() != 0) @(negedge clk);
  endtask

  initial begin : stimulus
    int                phase;
    int                phase_beats;
    int                len;
    int                stored;
    int                odd_max;
    int                odd;
    int                i;
    bit                forced_done;
    int                idle_plan [3];
    int                big_len [3];
    logic [DATA_W-1:0] gen_major;
    logic [DATA_W-1:0] alt_a;
    logic [DATA_W-1:0] alt_b;
    logic [TIME_W-1:0] ts_now;

    idle_plan = '{0, 86, 13};
    big_len = '{70, 40, 130};
    rst_n = 1'b0;
    start = 1'b0;
    in_data_byte = '0;
    in_end_of_packet = 1'b0;
    in_timestamp_us = '0;
    repeat (3) @(negedge clk);
    rst_n = 1'b1;

    pkt_q = '{8'h00};
    send_packet(32'hFFFF_FFF0);
    pkt_q = '{8'hFF};
    send_packet(32'h0000_0010);
    pkt_q = '{8'h12, 8'h34};
    send_packet(32'h0000_0100);
    pkt_q = '{8'hA5, 8'h5A, 8'hA5};
    send_packet(32'h8000_0000);
    pkt_q = '{8'h01, 8'h01, 8'h02, 8'h02};
    send_packet(32'h8000_1000);
    pkt_q = '{8'h0F, 8'hF0, 8'hFF, 8'hFF, 8'hFF};
    send_packet(32'hFFFF_FFFF);
    pkt_q = '{8'h10, 8'h20, 8'h20};
    send_packet(32'h0000_0000);
    pkt_q = '{8'h21, 8'h21};
    send_packet(32'h0000_0001);
    wait_drained();

    gen_major = 8'h21;
    ts_now = 32'h0000_0100;
    for (phase = 0; phase < 3; phase++) begin
      idle_pct = idle_plan[phase];
      phase_beats = 0;
      forced_done = 0;
      while (phase_beats < 90) begin
        if (!forced_done && phase_beats >= 20) begin
          len = big_len[phase];
          forced_done = 1;
        end else if ($urandom_range(29) == 0) begin
          len = $urandom_range(33, STORE_DEPTH);
        end else begin
          len = $urandom_range(1, 12);
        end
        stored = (len > STORE_DEPTH) ? STORE_DEPTH : len;
        pkt_q.delete();
        if ($urandom_range(99) < 85) begin
          if ($urandom_range(9) == 0) gen_major = DATA_W'($urandom);
          else gen_major = gen_major + 8'd1;
          for (i = 0; i < len; i++) pkt_q.push_back(i < stored ? gen_major : DATA_W'($urandom));
          odd_max = stored - stored / 2 - 1;
          odd = $urandom_range(0, odd_max);
          for (i = 0; i < odd; i++) begin
            pkt_q[$urandom_range(0, stored - 1)] ^= DATA_W'($urandom_range(1, 255));
          end
        end else if ($urandom_range(1) == 0) begin
          for (i = 0; i < len; i++) pkt_q.push_back(DATA_W'($urandom));
        end else begin
          alt_a = DATA_W'($urandom);
          alt_b = DATA_W'($urandom);
          for (i = 0; i < len; i++) pkt_q.push_back(i % 2 ? alt_b : alt_a);
        end
        if ($urandom_range(15) == 0) ts_now = TIME_W'($urandom);
        else ts_now = ts_now + TIME_W'($urandom_range(1, 100000));
        send_packet(ts_now);
        phase_beats += len;
      end
      wait_drained();
    end

    repeat (TAIL_CYCLES) @(negedge clk);
    if (sb.mismatches == 0 && sb.pending_count() == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule

// ===== sim.f =====
rtl/pmea_pkg.sv
rtl/pmea_ctrl.sv
rtl/pmea_dp.sv
rtl/packet_majority_error_analyzer.sv
tb/tb_packet_majority_error_analyzer.sv
